FILE: design/multichannel_comb_filter_assert.svh
// Assertion macros for the multichannel comb filter checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MULTICHANNEL_COMB_FILTER_ASSERT_SVH
`define MULTICHANNEL_COMB_FILTER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define MCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MCF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/mcf_pkg.sv
// Shared constants, types and helpers of the multichannel comb filter.
// No dependencies; used by every module of the block except the generic mcf_ram.
package mcf_pkg;

  // Sizing
  localparam int MAX_DELAY   = 1024;
  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 16;

  // Fixed field widths
  localparam int CHAN_BITS  = 3;
  localparam int GAIN_BITS  = 16;
  localparam int DELAY_BITS = 11;
  localparam int GAIN_FRAC  = 14;
  localparam int GAIN_ONE   = 16384;
  localparam int GAIN_HALF  = 8192;

  // Derived widths
  localparam int PTR_W     = $clog2(MAX_DELAY);
  localparam int DLY_W     = $clog2(MAX_DELAY + 1);
  localparam int DW        = (DLY_W > DELAY_BITS) ? DLY_W : DELAY_BITS;
  localparam int SLOT_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * MAX_DELAY;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int PROD_W    = GAIN_BITS + SAMPLE_BITS;
  localparam int SUM_W     = PROD_W + 1;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_GAIN  = 2'd0;
  localparam logic [PADDR_W-3:0] REG_DELAY = 2'd1;
  localparam logic [PADDR_W-3:0] REG_MODE  = 2'd2;

  // Register contents seen by the datapath
  typedef struct packed {
    logic signed [GAIN_BITS-1:0] gain;
    logic [DELAY_BITS-1:0]       delay_taps;
    logic                        feedback_mode;
  } cfg_t;

  // Tap addresses of one sample
  typedef struct packed {
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              hist_valid;
  } tap_t;

  // Channel field to slice index (channel modulo CHANNELS)
  function automatic logic [SLOT_W-1:0] chan_slot(input logic [CHAN_BITS-1:0] ch);
    int v;
    v = int'(ch);
    for (int i = 0; i < 7; i++) begin
      if (v >= CHANNELS) begin
        v = v - CHANNELS;
      end
    end
    return SLOT_W'(v);
  endfunction

endpackage

FILE: design/mcf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// A read at the address written in the same cycle returns the old data.
module mcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mcf_cfg.sv
// APB-style configuration registers: gain, delay and feedback mode.
// Depends on mcf_pkg.
module mcf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcf_pkg::PADDR_W-1:0]  paddr,
  input  logic [mcf_pkg::PDATA_W-1:0]  pwdata,
  output logic [mcf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output mcf_pkg::cfg_t                cfg_o
);

  logic signed [mcf_pkg::GAIN_BITS-1:0] gain_q, gain_d;
  logic [mcf_pkg::DELAY_BITS-1:0]       delay_q, delay_d;
  logic                                 mode_q, mode_d;
  logic                                 wr_en;
  logic [mcf_pkg::PADDR_W-3:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[mcf_pkg::PADDR_W-1:2];

  // Write decode
  always_comb begin
    gain_d  = gain_q;
    delay_d = delay_q;
    mode_d  = mode_q;
    if (wr_en) begin
      case (reg_idx)
        mcf_pkg::REG_GAIN:  gain_d  = pwdata[mcf_pkg::GAIN_BITS-1:0];
        mcf_pkg::REG_DELAY: delay_d = pwdata[mcf_pkg::DELAY_BITS-1:0];
        mcf_pkg::REG_MODE:  mode_d  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= '0;
      delay_q <= mcf_pkg::DELAY_BITS'(1);
      mode_q  <= 1'b0;
    end else begin
      gain_q  <= gain_d;
      delay_q <= delay_d;
      mode_q  <= mode_d;
    end
  end

  // Read mux, gain sign extended
  always_comb begin
    case (reg_idx)
      mcf_pkg::REG_GAIN:  prdata = mcf_pkg::PDATA_W'(gain_q);
      mcf_pkg::REG_DELAY: prdata = mcf_pkg::PDATA_W'(delay_q);
      mcf_pkg::REG_MODE:  prdata = mcf_pkg::PDATA_W'(mode_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.gain          = gain_q;
  assign cfg_o.delay_taps    = delay_q;
  assign cfg_o.feedback_mode = mode_q;

endmodule

FILE: design/mcf_tap.sv
// Per-channel write pointers and fill flags; forms the read and write taps.
// Depends on mcf_pkg.
module mcf_tap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic [mcf_pkg::CHAN_BITS-1:0]    chan_i,
  input  logic [mcf_pkg::DELAY_BITS-1:0]   delay_taps_i,
  output mcf_pkg::tap_t                    tap_o
);

  logic [mcf_pkg::PTR_W-1:0]  wp_q [mcf_pkg::CHANNELS];
  logic [mcf_pkg::PTR_W-1:0]  wp_d [mcf_pkg::CHANNELS];
  logic [mcf_pkg::CHANNELS-1:0] wrap_q, wrap_d;

  logic [mcf_pkg::SLOT_W-1:0] slot;
  logic [mcf_pkg::PTR_W-1:0]  wp, rd, wp_next;
  logic                       wp_last;
  logic [mcf_pkg::DW-1:0]     d_raw, d_clamp, wp_ext;
  logic [mcf_pkg::ADDR_W-1:0] base;

  assign slot    = mcf_pkg::chan_slot(chan_i);
  assign wp      = wp_q[slot];
  assign wp_last = (wp == mcf_pkg::PTR_W'(mcf_pkg::MAX_DELAY - 1));
  assign wp_next = wp_last ? '0 : wp + mcf_pkg::PTR_W'(1);

  // Delay limited to 1..MAX_DELAY
  always_comb begin
    d_raw = mcf_pkg::DW'(delay_taps_i);
    if (d_raw == '0) begin
      d_clamp = mcf_pkg::DW'(1);
    end else if (d_raw > mcf_pkg::DW'(mcf_pkg::MAX_DELAY)) begin
      d_clamp = mcf_pkg::DW'(mcf_pkg::MAX_DELAY);
    end else begin
      d_clamp = d_raw;
    end
  end

  // Read slot = (wp - delay) mod MAX_DELAY
  assign wp_ext = mcf_pkg::DW'(wp);
  assign rd = (wp_ext >= d_clamp) ? mcf_pkg::PTR_W'(wp_ext - d_clamp)
            : mcf_pkg::PTR_W'(wp_ext + mcf_pkg::DW'(mcf_pkg::MAX_DELAY) - d_clamp);

  assign base = mcf_pkg::ADDR_W'(slot) * mcf_pkg::ADDR_W'(mcf_pkg::MAX_DELAY);

  assign tap_o.raddr      = base + mcf_pkg::ADDR_W'(rd);
  assign tap_o.waddr      = base + mcf_pkg::ADDR_W'(wp);
  // Slots below the pointer, or all slots after a wrap, hold written history
  assign tap_o.hist_valid = wrap_q[slot] || (rd < wp);

  // Pointer advance on each transfer
  always_comb begin
    wp_d   = wp_q;
    wrap_d = wrap_q;
    if (acc_i) begin
      wp_d[slot] = wp_next;
      if (wp_last) begin
        wrap_d[slot] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mcf_pkg::CHANNELS; i++) begin
        wp_q[i] <= '0;
      end
      wrap_q <= '0;
    end else begin
      wp_q   <= wp_d;
      wrap_q <= wrap_d;
    end
  end

endmodule

FILE: design/multichannel_comb_filter.sv
// Multichannel comb filter: y = x + gain * delayed, per-channel ring buffers.
// Samples pass the stage 1 and output registers; one sample per cycle is sustained unless the
// output stalls. The delay memory is read when a sample is taken and written as it leaves
// stage 1; a same-slot write in the read cycle is forwarded. Rate is set by that one RAM port pair.
// Reset clears control registers, pointers and fill flags at once; no memory clearing pass:
// history not yet written since reset reads as zero. Depends on mcf_pkg, mcf_ram, mcf_cfg, mcf_tap.
module multichannel_comb_filter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Sample input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mcf_pkg::CHAN_BITS-1:0]         channel_i,
  input  logic signed [mcf_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                  frame_end_i,
  // Result output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mcf_pkg::CHAN_BITS-1:0]         out_channel_o,
  output logic signed [mcf_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                  block_end_o,
  // Configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mcf_pkg::PADDR_W-1:0]           paddr,
  input  logic [mcf_pkg::PDATA_W-1:0]           pwdata,
  output logic [mcf_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int SB = mcf_pkg::SAMPLE_BITS;
  localparam logic signed [mcf_pkg::SUM_W-1:0] SAT_HI =
    mcf_pkg::SUM_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [mcf_pkg::SUM_W-1:0] SAT_LO = -SAT_HI - 1;
  localparam logic signed [mcf_pkg::GAIN_BITS-1:0] G_HI =
    mcf_pkg::GAIN_BITS'(mcf_pkg::GAIN_ONE);
  localparam logic signed [mcf_pkg::GAIN_BITS-1:0] G_LO = -G_HI;

  mcf_pkg::cfg_t cfg;
  mcf_pkg::tap_t tap;

  logic in_acc, s1_adv, out_free;

  // Stage 1 registers
  logic                             s1_valid_q, s1_valid_d;
  logic [mcf_pkg::CHAN_BITS-1:0]    s1_chan_q;
  logic signed [SB-1:0]             s1_x_q;
  logic                             s1_end_q;
  logic [mcf_pkg::ADDR_W-1:0]       s1_waddr_q;
  logic                             s1_hist_q;
  logic                             s1_fwd_q;
  logic signed [SB-1:0]             s1_fwd_data_q;

  // Output registers
  logic                             out_valid_q, out_valid_d;
  logic [mcf_pkg::CHAN_BITS-1:0]    out_chan_q;
  logic signed [SB-1:0]             out_y_q;
  logic                             out_end_q;

  // Datapath
  logic [SB-1:0]                        ram_rdata;
  logic signed [SB-1:0]                 delayed, y, wdata;
  logic signed [mcf_pkg::GAIN_BITS-1:0] g_clamp;
  logic signed [mcf_pkg::PROD_W-1:0]    g_ext, d_ext, prod, rnd_sum, rnd;
  logic signed [mcf_pkg::SUM_W-1:0]     y_sum;
  logic                                 fwd_hit;

  mcf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcf_tap u_tap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .chan_i       (channel_i),
    .delay_taps_i (cfg.delay_taps),
    .tap_o        (tap)
  );

  mcf_ram #(
    .WIDTH (SB),
    .DEPTH (mcf_pkg::MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_waddr_q),
    .wdata_i (wdata),
    .re_i    (in_acc),
    .raddr_i (tap.raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and stage advance
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Write to the slot being read in the same cycle is forwarded
  assign fwd_hit = s1_adv && (s1_waddr_q == tap.raddr);

  // Delayed value: forwarded, stored, or zero for unwritten history
  always_comb begin
    if (s1_fwd_q) begin
      delayed = s1_fwd_data_q;
    end else if (s1_hist_q) begin
      delayed = $signed(ram_rdata);
    end else begin
      delayed = '0;
    end
  end

  // Gain limited to -1..+1
  always_comb begin
    if (cfg.gain > G_HI) begin
      g_clamp = G_HI;
    end else if (cfg.gain < G_LO) begin
      g_clamp = G_LO;
    end else begin
      g_clamp = cfg.gain;
    end
  end

  // Multiply, round to nearest (half up), add and saturate
  assign g_ext   = mcf_pkg::PROD_W'(g_clamp);
  assign d_ext   = mcf_pkg::PROD_W'(delayed);
  assign prod    = g_ext * d_ext;
  assign rnd_sum = prod + mcf_pkg::PROD_W'(mcf_pkg::GAIN_HALF);
  assign rnd     = rnd_sum >>> mcf_pkg::GAIN_FRAC;
  assign y_sum   = mcf_pkg::SUM_W'(s1_x_q) + mcf_pkg::SUM_W'(rnd);

  always_comb begin
    if (y_sum > SAT_HI) begin
      y = SB'(SAT_HI);
    end else if (y_sum < SAT_LO) begin
      y = SB'(SAT_LO);
    end else begin
      y = SB'(y_sum);
    end
  end

  assign wdata = cfg.feedback_mode ? y : s1_x_q;

  // Stage 1 control
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Output control
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      s1_fwd_q    <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        s1_fwd_q <= fwd_hit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_chan_q     <= channel_i;
      s1_x_q        <= sample_in_i;
      s1_end_q      <= frame_end_i;
      s1_waddr_q    <= tap.waddr;
      s1_hist_q     <= tap.hist_valid;
      s1_fwd_data_q <= wdata;
    end
    if (s1_adv) begin
      out_chan_q <= s1_chan_q;
      out_y_q    <= y;
      out_end_q  <= s1_end_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_chan_q;
  assign sample_out_o  = out_y_q;
  assign block_end_o   = out_end_q;

endmodule

FILE: design/mcf_checker.sv
// Port-level checker for the multichannel comb filter, bound to the top level.
// Depends on mcf_pkg and multichannel_comb_filter_assert.svh.
`include "multichannel_comb_filter_assert.svh"

module mcf_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic [mcf_pkg::CHAN_BITS-1:0]         out_channel_o,
  input logic signed [mcf_pkg::SAMPLE_BITS-1:0] sample_out_o,
  input logic                                  block_end_o,
  input logic                                  pready
);

  // A stalled result holds its payload
  `MCF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o) && $stable(out_channel_o) && $stable(block_end_o), "stalled result changed")

  // Configuration writes never wait
  `MCF_ASSERT(a_pready, pready, "pready dropped")

  // A result appearing on an idle output comes from an input transfer through stage 1
  `MCF_ASSERT(a_latency, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "result without matching input transfer")

  // No result while in reset
  `MCF_ASSERT_RST(a_rst_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind multichannel_comb_filter mcf_checker u_mcf_checker (.*);

FILE: verif/multichannel_comb_filter_tb.sv
// Self-checking testbench for the multichannel comb filter: directed and random sample
// streams checked against a per-channel ring buffer predictor. Depends on mcf_pkg and the RTL.
module multichannel_comb_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One filtered sample as it should leave the block
  typedef struct {
    logic [mcf_pkg::CHAN_BITS-1:0]          chan;
    logic signed [mcf_pkg::SAMPLE_BITS-1:0] smp;
    logic                                   fe;
  } comb_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                                   in_valid;
  logic                                   in_ready;
  logic [mcf_pkg::CHAN_BITS-1:0]          channel;
  logic signed [mcf_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                   frame_end;
  logic                                   out_valid;
  logic                                   out_ready;
  logic [mcf_pkg::CHAN_BITS-1:0]          out_channel;
  logic signed [mcf_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                   block_end;
  logic                                   psel;
  logic                                   penable;
  logic                                   pwrite;
  logic [mcf_pkg::PADDR_W-1:0]            paddr;
  logic [mcf_pkg::PDATA_W-1:0]            pwdata;
  logic [mcf_pkg::PDATA_W-1:0]            prdata;
  logic                                   pready;

  // Predictor state: register copies, delay lines and write pointers
  logic signed [mcf_pkg::GAIN_BITS-1:0]   gain_q;
  logic [mcf_pkg::DELAY_BITS-1:0]         delay_q;
  logic                                   fb_q;
  logic signed [mcf_pkg::SAMPLE_BITS-1:0] hist_mem [mcf_pkg::CHANNELS*mcf_pkg::MAX_DELAY];
  int unsigned                            wr_ptr [mcf_pkg::CHANNELS];
  comb_out_t                              filtered_q [$];

  int err_count = 0;
  int hold_len  = 0;
  bit tx_gaps   = 1'b0;
  bit rx_stalls = 1'b0;

  multichannel_comb_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .channel_i     (channel),
    .sample_in_i   (sample_in),
    .frame_end_i   (frame_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_channel_o (out_channel),
    .sample_out_o  (sample_out),
    .block_end_o   (block_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Comb arithmetic for one accepted sample; queues the filtered result
  function automatic void comb_predict(input logic [mcf_pkg::CHAN_BITS-1:0] ch,
                                       input logic signed [mcf_pkg::SAMPLE_BITS-1:0] x,
                                       input logic fe);
    int unsigned slot, wp, rd, taps;
    longint      g, d, y;
    comb_out_t   r;
    slot = int'(ch) % mcf_pkg::CHANNELS;
    g = gain_q;
    if (g > mcf_pkg::GAIN_ONE) g = mcf_pkg::GAIN_ONE;
    if (g < -mcf_pkg::GAIN_ONE) g = -mcf_pkg::GAIN_ONE;
    taps = delay_q;
    if (taps < 1) taps = 1;
    if (taps > mcf_pkg::MAX_DELAY) taps = mcf_pkg::MAX_DELAY;
    wp = wr_ptr[slot];
    rd = (wp + mcf_pkg::MAX_DELAY - taps) % mcf_pkg::MAX_DELAY;
    d = hist_mem[slot*mcf_pkg::MAX_DELAY + rd];
    // round half up to Q1.15: floor((g*d + 2^13) / 2^14)
    y = longint'(x) + ((g * d + mcf_pkg::GAIN_HALF) >>> mcf_pkg::GAIN_FRAC);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    hist_mem[slot*mcf_pkg::MAX_DELAY + wp] = fb_q ? mcf_pkg::SAMPLE_BITS'(y) : x;
    wr_ptr[slot] = (wp + 1) % mcf_pkg::MAX_DELAY;
    r.chan = ch;
    r.smp  = mcf_pkg::SAMPLE_BITS'(y);
    r.fe   = fe;
    filtered_q.push_back(r);
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [mcf_pkg::SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  // Gain values: unity, minus unity, raw 16-bit (often clamped), small, in range
  function automatic logic [mcf_pkg::GAIN_BITS-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'(mcf_pkg::GAIN_ONE);
      1: return 16'(-mcf_pkg::GAIN_ONE);
      2: return 16'($urandom());
      3: return 16'($urandom_range(0, 400) - 200);
      default: return 16'($urandom_range(0, 2*mcf_pkg::GAIN_ONE) - mcf_pkg::GAIN_ONE);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  // One sample transfer; valid stays up on return so a following call can chain
  task automatic send_sample(input logic [mcf_pkg::CHAN_BITS-1:0] ch,
                             input logic [mcf_pkg::SAMPLE_BITS-1:0] x, input logic fe);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    channel   <= ch;
    sample_in <= x;
    frame_end <= fe;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    comb_predict(ch, x, fe);
  endtask

  // Stop sending and wait until every filtered sample has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: setup phase, access phase, then an idle phase
  task automatic cfg_write(input logic [mcf_pkg::PADDR_W-3:0] idx,
                           input logic [mcf_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      mcf_pkg::REG_GAIN:  gain_q  = val[mcf_pkg::GAIN_BITS-1:0];
      mcf_pkg::REG_DELAY: delay_q = val[mcf_pkg::DELAY_BITS-1:0];
      mcf_pkg::REG_MODE:  fb_q    = val[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [mcf_pkg::GAIN_BITS-1:0] g, input int taps,
                            input bit fb);
    wait_drained();
    cfg_write(mcf_pkg::REG_GAIN, {16'h0, g});
    cfg_write(mcf_pkg::REG_DELAY, mcf_pkg::PDATA_W'(taps));
    cfg_write(mcf_pkg::REG_MODE, {31'h0, fb});
  endtask

  task automatic send_random(input int count);
    repeat (count)
      send_sample(3'($urandom_range(0, 7)), rand_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Saturation, unity gains, rounding, gain clamp and delay of zero
  task automatic test_directed();
    // reset gain is zero: samples pass through
    send_sample(3'd0, 16'h7FFF, 1'b0);
    send_sample(3'd1, 16'h8000, 1'b1);
    send_sample(3'd7, 16'h0000, 1'b0);
    set_config(16'(mcf_pkg::GAIN_ONE), 1, 1'b0);
    send_sample(3'd2, 16'h7FFF, 1'b0);
    send_sample(3'd2, 16'h7FFF, 1'b0);
    send_sample(3'd2, 16'h8000, 1'b0);
    send_sample(3'd2, 16'h8000, 1'b1);
    set_config(16'(-mcf_pkg::GAIN_ONE), 1, 1'b0);
    send_sample(3'd3, 16'h8000, 1'b0);
    send_sample(3'd3, 16'h8000, 1'b0);
    send_sample(3'd3, 16'h7FFF, 1'b1);
    // smallest gain: rounding of the product at the half point
    set_config(16'd1, 1, 1'b0);
    send_sample(3'd4, 16'sd8192, 1'b0);
    send_sample(3'd4, 16'sd0, 1'b0);
    send_sample(3'd4, -16'sd8192, 1'b0);
    send_sample(3'd4, 16'sd0, 1'b0);
    send_sample(3'd4, -16'sd8193, 1'b0);
    send_sample(3'd4, 16'sd0, 1'b1);
    // gains beyond plus and minus one are clamped
    set_config(16'h7FFF, 1, 1'b0);
    send_sample(3'd5, 16'sd1000, 1'b0);
    send_sample(3'd5, 16'sd0, 1'b0);
    set_config(16'h8000, 1, 1'b0);
    send_sample(3'd5, 16'sd1000, 1'b0);
    send_sample(3'd5, 16'sd0, 1'b1);
    // delay zero behaves as one, feedback stores the output
    set_config(16'(mcf_pkg::GAIN_ONE), 0, 1'b1);
    send_sample(3'd6, 16'sd100, 1'b0);
    send_sample(3'd6, 16'sd100, 1'b0);
    send_sample(3'd6, 16'sd100, 1'b1);
  endtask

  task automatic test_feedforward_random();
    // first stretch without idling on either side
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    set_config(rand_gain(), $urandom_range(1, 8), 1'b0);
    send_random(125);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    set_config(rand_gain(), $urandom_range(1, 8), 1'b0);
    send_random(125);
  endtask

  task automatic test_feedback_random();
    set_config(16'(mcf_pkg::GAIN_ONE), $urandom_range(1, 16), 1'b1);
    send_random(125);
    // sender pause until every result is back, same settings
    wait_drained();
    send_random(25);
    set_config(rand_gain(), $urandom_range(1, 16), 1'b1);
    send_random(100);
  endtask

  // One channel gets nearly all samples so its pointer wraps and long taps see history
  task automatic test_long_delay_wrap();
    set_config(rand_gain(), mcf_pkg::MAX_DELAY, 1'($urandom_range(0, 1)));
    repeat (550)
      send_sample(($urandom_range(0, 99) < 97) ? 3'd5 : 3'($urandom_range(0, 7)),
                  rand_sample(), 1'($urandom_range(0, 1)));
    // delay change keeps the history, only the read tap moves
    set_config(rand_gain(), $urandom_range(600, 1000), 1'($urandom_range(0, 1)));
    repeat (550)
      send_sample(($urandom_range(0, 99) < 97) ? 3'd5 : 3'($urandom_range(0, 7)),
                  rand_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Receiver holds off while the sender keeps offering samples
  task automatic test_backpressure();
    set_config(rand_gain(), $urandom_range(1, 32), 1'($urandom_range(0, 1)));
    tx_gaps  = 1'b0;
    hold_len = 200;
    send_random(150);
    tx_gaps  = 1'b1;
  endtask

  // Delay above the maximum or zero, and raw full-width gains
  task automatic test_delay_clamp();
    set_config(16'($urandom()), 2047, 1'b0);
    send_random(50);
    set_config(16'($urandom()), 0, 1'b1);
    send_random(50);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        n = hold_len;
        out_ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
        hold_len = 0;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest predicted sample
  always @(posedge clk_i) begin : result_check
    comb_out_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("result with none pending", sample_out, 0);
      end else begin
        e = filtered_q.pop_front();
        if (out_channel !== e.chan) report_mismatch("out_channel", out_channel, e.chan);
        if (sample_out !== e.smp) report_mismatch("sample_out", sample_out, e.smp);
        if (block_end !== e.fe) report_mismatch("block_end", block_end, e.fe);
      end
    end
  end

  initial begin : watchdog
    #10ms;
    $display("FAIL");
    $finish;
  end

  initial begin : main
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    channel   <= '0;
    sample_in <= '0;
    frame_end <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    gain_q  = '0;
    delay_q = 11'd1;
    fb_q    = 1'b0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    foreach (wr_ptr[i]) wr_ptr[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_feedforward_random();
    test_feedback_random();
    test_long_delay_wrap();
    test_backpressure();
    test_delay_clamp();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && filtered_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/mcf_pkg.sv
design/mcf_ram.sv
design/mcf_cfg.sv
design/mcf_tap.sv
design/multichannel_comb_filter.sv
design/mcf_checker.sv
verif/multichannel_comb_filter_tb.sv
